// ----- hw/rtl/dfd_pkg.sv -----
// Shared constants, codes and the result type for the delimited frame deframer.
package dfd_pkg;

    // Delimiter bytes of a frame.
    localparam logic [7:0] START_FIRST  = 8'h41;
    localparam logic [7:0] START_SECOND = 8'h5A;
    localparam logic [7:0] END_FIRST    = 8'h59;
    localparam logic [7:0] END_SECOND   = 8'h42;

    // Range of known system ids.
    localparam logic [7:0] ID_LOW  = 8'h01;
    localparam logic [7:0] ID_MID  = 8'h02;
    localparam logic [7:0] ID_HIGH = 8'h03;

    // Payload geometry.
    localparam int PAYLOAD_BYTES = 8;
    localparam int INDEX_W       = $clog2(PAYLOAD_BYTES);
    localparam int STREAMS       = 3;

    // Parser phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_WAIT1   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT2   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_COLLECT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_END1    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_END2    = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_FRAME   = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  system_id;
        logic [7:0]  mode;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [7:0]  z_value;
        logic [7:0]  yaw_value;
        logic [15:0] frame_count;
        logic [15:0] error_count;
    } result_t;

endpackage

// ----- hw/rtl/dfd_byte_if.sv -----
// Valid/ready channel that carries one received byte per item.
interface dfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/dfd_result_if.sv -----
// Valid/ready channel that carries one decoded frame or event report per item.
interface dfd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  system_id;
    logic [7:0]  mode;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [7:0]  z_value;
    logic [7:0]  yaw_value;
    logic [15:0] frame_count;
    logic [15:0] error_count;

    modport source (
        output valid, output status, output system_id, output mode,
        output x_value, output y_value, output z_value, output yaw_value,
        output frame_count, output error_count, input ready
    );
    modport sink (
        input valid, input status, input system_id, input mode,
        input x_value, input y_value, input z_value, input yaw_value,
        input frame_count, input error_count, output ready
    );
endinterface

// ----- hw/rtl/dfd_parser.sv -----
// Frame parser: phase machine, payload store, counters and result decode.
module dfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              emit,
    output dfd_pkg::result_t  result
);

    logic [dfd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [dfd_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [7:0]                  store_reg [dfd_pkg::PAYLOAD_BYTES];
    logic                        store_we;
    logic [15:0]                 errors_reg, errors_next;
    logic [15:0]                 counts_reg [dfd_pkg::STREAMS];
    logic [15:0]                 count_inc;
    logic                        emit_error;
    logic                        emit_frame;
    logic                        id_known;
    logic [7:0]                  frame_id;

    assign frame_id = store_reg[0];
    assign id_known = (frame_id == dfd_pkg::ID_LOW) || (frame_id == dfd_pkg::ID_MID) ||
                      (frame_id == dfd_pkg::ID_HIGH);

    // Phase machine: next phase, store write and event decode for the current byte.
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        store_we   = 1'b0;
        emit_error = 1'b0;
        emit_frame = 1'b0;
        unique case (phase_reg)
            dfd_pkg::PH_WAIT1:
            begin
                if (rx_byte == dfd_pkg::START_FIRST)
                begin
                    phase_next = dfd_pkg::PH_WAIT2;
                end
            end
            dfd_pkg::PH_WAIT2:
            begin
                if (rx_byte == dfd_pkg::START_SECOND)
                begin
                    index_next = '0;
                    phase_next = dfd_pkg::PH_COLLECT;
                end
                else if (rx_byte != dfd_pkg::START_FIRST)
                begin
                    phase_next = dfd_pkg::PH_WAIT1;
                    emit_error = 1'b1;
                end
            end
            dfd_pkg::PH_COLLECT:
            begin
                store_we   = 1'b1;
                index_next = index_reg + 1'b1;
                if (index_reg == dfd_pkg::INDEX_W'(dfd_pkg::PAYLOAD_BYTES - 1))
                begin
                    phase_next = dfd_pkg::PH_END1;
                end
            end
            dfd_pkg::PH_END1:
            begin
                if (rx_byte == dfd_pkg::END_FIRST)
                begin
                    phase_next = dfd_pkg::PH_END2;
                end
                else
                begin
                    phase_next = dfd_pkg::PH_WAIT1;
                    emit_error = 1'b1;
                end
            end
            dfd_pkg::PH_END2:
            begin
                phase_next = dfd_pkg::PH_WAIT1;
                if (rx_byte == dfd_pkg::END_SECOND)
                begin
                    emit_frame = 1'b1;
                end
                else
                begin
                    emit_error = 1'b1;
                end
            end
            default:
            begin
                phase_next = dfd_pkg::PH_WAIT1;
            end
        endcase
    end

    assign errors_next = emit_error ? errors_reg + 16'd1 : errors_reg;

    // Updated count of the stream named by the frame id.
    always_comb
    begin
        case (frame_id)
            dfd_pkg::ID_LOW:  count_inc = counts_reg[0] + 16'd1;
            dfd_pkg::ID_MID:  count_inc = counts_reg[1] + 16'd1;
            default:          count_inc = counts_reg[2] + 16'd1;
        endcase
    end

    // Result assembly; fields that do not apply stay zero.
    always_comb
    begin
        result             = '0;
        result.error_count = errors_next;
        if (emit_error)
        begin
            result.status = dfd_pkg::ST_ERROR;
        end
        else if (emit_frame && !id_known)
        begin
            result.status    = dfd_pkg::ST_DROPPED;
            result.system_id = frame_id;
        end
        else if (emit_frame)
        begin
            result.status      = dfd_pkg::ST_FRAME;
            result.system_id   = frame_id;
            result.mode        = store_reg[1];
            result.x_value     = {store_reg[2], store_reg[3]};
            result.y_value     = {store_reg[4], store_reg[5]};
            result.z_value     = store_reg[6];
            result.yaw_value   = store_reg[7];
            result.frame_count = count_inc;
        end
    end

    assign emit = emit_error || emit_frame;

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dfd_pkg::PH_WAIT1;
            index_reg  <= '0;
            errors_reg <= '0;
            for (int i = 0; i < dfd_pkg::STREAMS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            errors_reg <= errors_next;
            if (emit_frame && id_known)
            begin
                case (frame_id)
                    dfd_pkg::ID_LOW: counts_reg[0] <= count_inc;
                    dfd_pkg::ID_MID: counts_reg[1] <= count_inc;
                    default:         counts_reg[2] <= count_inc;
                endcase
            end
        end
    end

    // Payload bytes; every entry is written before a completed frame reads it.
    always_ff @(posedge clk)
    begin
        if (step && store_we)
        begin
            store_reg[index_reg] <= rx_byte;
        end
    end

    // A reported framing error advances the error counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && (result.status == dfd_pkg::ST_ERROR)
        |=> errors_reg == 16'($past(errors_reg) + 16'd1))
        else $error("error counter did not advance on a framing error");

    // Frames and dropped frames come only from the last end byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && (result.status != dfd_pkg::ST_ERROR) |-> phase_reg == dfd_pkg::PH_END2)
        else $error("frame reported outside the final end byte");

    // Bytes seen while hunting for the first start byte never produce an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dfd_pkg::PH_WAIT1 |-> !emit)
        else $error("result produced while waiting for a start byte");

    // The error counter moves only on a step that reports an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(step && emit && (result.status == dfd_pkg::ST_ERROR)) |=> $stable(errors_reg))
        else $error("error counter changed without a framing error");

endmodule

// ----- hw/rtl/dfd_result_reg.sv -----
// Output register that holds one result item until the sink takes it.
module dfd_result_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  dfd_pkg::result_t     result,
    output logic                 free,
    dfd_result_if.source         result_out
);

    logic             valid_reg, valid_next;
    dfd_pkg::result_t data_reg;

    assign free = !valid_reg || result_out.ready;

    // Valid flag: set on load, cleared when taken with nothing new behind it.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign result_out.valid       = valid_reg;
    assign result_out.status      = data_reg.status;
    assign result_out.system_id   = data_reg.system_id;
    assign result_out.mode        = data_reg.mode;
    assign result_out.x_value     = data_reg.x_value;
    assign result_out.y_value     = data_reg.y_value;
    assign result_out.z_value     = data_reg.z_value;
    assign result_out.yaw_value   = data_reg.yaw_value;
    assign result_out.frame_count = data_reg.frame_count;
    assign result_out.error_count = data_reg.error_count;

endmodule

// ----- hw/rtl/delimited_frame_deframer_unit.sv -----
// Top level of the delimited frame deframer: input register, parser, output register.
// The result of a byte that completes or breaks a frame enters the output register
// when that byte steps out of the input register. Throughput: one byte per cycle while the
// output register is free; a result left waiting stalls the input after one more byte.
// Reset (rst_n, asynchronous, active low) clears the phase, the error counter and the
// three stream counters and empties both registers; the payload bytes are not cleared.
module delimited_frame_deframer_unit (
    input  logic          clk,
    input  logic          rst_n,
    dfd_byte_if.sink      byte_in,
    dfd_result_if.source  result_out
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_free;
    logic             step;
    logic             emit;
    logic             in_take;
    dfd_pkg::result_t result;

    // The held byte moves on whenever the output register can take its result.
    assign step          = in_valid_reg && out_free;
    assign byte_in.ready = !in_valid_reg || out_free;
    assign in_take       = byte_in.valid && byte_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_in.rx_byte;
        end
    end

    dfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    dfd_result_reg u_result_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && emit),
        .result     (result),
        .free       (out_free),
        .result_out (result_out)
    );

endmodule
